[hdl/itc_pkg.sv]
// Shared types, codes and constants of the word machine instruction stepper.
`timescale 1ns / 1ps

package itc_pkg;

   localparam int MEMORY_WORDS = 4096;
   localparam int ADDR_W       = $clog2(MEMORY_WORDS);
   localparam int PC_W         = $clog2(MEMORY_WORDS + 1);

   localparam logic [1:0] CMD_LOAD    = 2'd0;
   localparam logic [1:0] CMD_RESTART = 2'd1;
   localparam logic [1:0] CMD_STEP    = 2'd2;

   localparam logic [6:0] OP_ADD  = 7'd1;
   localparam logic [6:0] OP_MUL  = 7'd2;
   localparam logic [6:0] OP_IN   = 7'd3;
   localparam logic [6:0] OP_OUT  = 7'd4;
   localparam logic [6:0] OP_JT   = 7'd5;
   localparam logic [6:0] OP_JF   = 7'd6;
   localparam logic [6:0] OP_LT   = 7'd7;
   localparam logic [6:0] OP_EQ   = 7'd8;
   localparam logic [6:0] OP_ADJ  = 7'd9;
   localparam logic [6:0] OP_HALT = 7'd99;

   localparam logic [1:0] MODE_POS = 2'd0;
   localparam logic [1:0] MODE_IMM = 2'd1;
   localparam logic [1:0] MODE_REL = 2'd2;

   typedef enum logic [3:0] {
      ST_EXECUTED    = 4'd0,
      ST_OUTPUT      = 4'd1,
      ST_WAITING     = 4'd2,
      ST_HALTED      = 4'd3,
      ST_DONE        = 4'd4,
      ST_BAD_OPCODE  = 4'd5,
      ST_BAD_MODE    = 4'd6,
      ST_BAD_ADDRESS = 4'd7,
      ST_IMM_DEST    = 4'd8
   } status_type;

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_DEC, S_DIV, S_MODES, S_DIGITS, S_CHECK,
      S_RAW_RD, S_RAW_LAT, S_SRC, S_SRC_LAT, S_DST, S_EXEC,
      S_MUL_HL, S_MUL_LH, S_MUL_WR
   } state_type;

   typedef enum logic [2:0] {
      MEM_IDLE, MEM_RD_PC, MEM_RD_RAW, MEM_RD_OPND,
      MEM_WR_LOAD, MEM_WR_RESULT, MEM_WR_CLEAR
   } mem_sel_type;

   typedef enum logic [1:0] {
      MUL_NONE, MUL_LL, MUL_HL, MUL_LH
   } mul_sel_type;

   typedef struct packed {
      logic [1:0]         cmd;
      logic [11:0]        load_address;
      logic signed [63:0] load_data;
      logic               input_valid;
      logic signed [63:0] input_value;
   } req_type;

   typedef struct packed {
      logic [3:0]         status;
      logic signed [63:0] output_value;
      logic               input_taken;
   } rsp_type;

   typedef struct packed {
      logic       valid;
      logic [1:0] nsrc;
      logic       ndst;
   } op_info_type;

   typedef struct packed {
      mem_sel_type mem_sel;
      mul_sel_type mul_sel;
      logic        lat_req;
      logic        lat_dec;
      logic        lat_div;
      logic        lat_modes;
      logic        lat_digits;
      logic        lat_raw;
      logic        lat_val_imm;
      logic        lat_val_mem;
      logic        lat_dst;
      logic        idx_clr;
      logic        idx_inc;
      logic        clr_inc;
      logic        restart;
      logic        set_halt;
      logic        pc_jump;
      logic        pc_advance;
      logic        base_add;
      logic        rsp_fire;
      logic        rsp_out;
      logic        rsp_taken;
      status_type  rsp_status;
   } ctrl_type;

   typedef struct packed {
      logic       clear_done;
      logic [1:0] in_cmd;
      logic       in_load_bad;
      logic       halted;
      logic       pc_bad;
      logic       word_neg;
      logic       word_big;
      logic       mode_bad;
      logic [6:0] op;
      logic       op_valid;
      logic [1:0] nsrc;
      logic       ndst;
      logic [1:0] ntot;
      logic       input_valid;
      logic       pc_over;
      logic [1:0] idx;
      logic       cur_imm;
      logic       cur_addr_bad;
      logic       jump_take;
      logic       target_bad;
   } stat_type;

   function automatic op_info_type op_info(logic [6:0] op);
      op_info_type r;
      r = '0;
      unique case (op)
         OP_ADD, OP_MUL, OP_LT, OP_EQ: r = '{valid: 1'b1, nsrc: 2'd2, ndst: 1'b1};
         OP_IN:                        r = '{valid: 1'b1, nsrc: 2'd0, ndst: 1'b1};
         OP_OUT, OP_ADJ:               r = '{valid: 1'b1, nsrc: 2'd1, ndst: 1'b0};
         OP_JT, OP_JF:                 r = '{valid: 1'b1, nsrc: 2'd2, ndst: 1'b0};
         default:                      r = '0;
      endcase
      return r;
   endfunction

endpackage

[hdl/intcode_instruction_stepper.sv]
// Top level of the decimal-encoded word machine instruction stepper.
// A transaction is accepted at a rising edge where start is high and busy is low;
// req_item carries the command (load word, restart, or execute one instruction).
// Each transaction yields exactly one result on rsp_item, marked by rsp_valid for
// one cycle; the receiver always takes it and cannot hold it off.
// Load, restart and unused commands answer in the cycle after acceptance, and
// busy stays low so the next transaction can follow at once. So does an execute
// on a halted machine or with the counter beyond the last memory word.
// An execute transaction walks a single memory port through the decode and check
// states (S_DEC, S_DIV, S_MODES, S_DIGITS, S_CHECK), a read and latch state per
// operand word, a state per source (plus a latch state for each memory source),
// a destination state and an execute state, with S_MUL_HL, S_MUL_LH and S_MUL_WR
// added for a multiply; the result appears in the cycle in which busy drops.
// After reset the machine clears all 4096 memory words, one per cycle, holding
// busy high until the clear ends; the counter, base and halt flag reset to zero.
`timescale 1ns / 1ps

module intcode_instruction_stepper (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  itc_pkg::req_type req_item,
   output logic             rsp_valid,
   output itc_pkg::rsp_type rsp_item
);

   itc_pkg::ctrl_type ctrl;
   itc_pkg::stat_type st;

   itc_controller u_controller (
      .clock (clock),
      .reset (reset),
      .start (start),
      .st    (st),
      .busy  (busy),
      .ctrl  (ctrl)
   );

   itc_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .ctrl      (ctrl),
      .st        (st),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule

[hdl/itc_datapath.sv]
// Datapath of the stepper: word memory, machine registers, decoder, multiplier and results.
`timescale 1ns / 1ps

module itc_datapath (
   input  logic              clock,
   input  logic              reset,
   input  itc_pkg::req_type  req_item,
   input  itc_pkg::ctrl_type ctrl,
   output itc_pkg::stat_type st,
   output logic              rsp_valid,
   output itc_pkg::rsp_type  rsp_item
);

   logic [63:0] word_mem [itc_pkg::MEMORY_WORDS];
   logic [63:0] rdata_ff;
   logic [itc_pkg::ADDR_W-1:0] mem_addr;
   logic [63:0] mem_wdata;
   logic mem_we;

   itc_pkg::req_type req_ff;
   logic [itc_pkg::PC_W-1:0] pc_ff;
   logic [63:0] base_ff;
   logic halted_ff;
   logic [itc_pkg::ADDR_W-1:0] clr_ff;
   logic [1:0] idx_ff;

   logic [16:0] x_ff;
   logic [10:0] q0_ff;
   logic neg_ff, big_ff;
   logic [9:0] m_ff;
   logic [6:0] op_ff;
   logic [6:0] q1_ff;
   logic [3:0] d0_ff;
   logic [1:0] mode_ff [3];
   logic mode_bad_ff;

   logic [63:0] raw_ff [3];
   logic [63:0] val_ff [2];
   logic [itc_pkg::ADDR_W-1:0] dst_ff;
   logic [63:0] acc_ff;

   logic rsp_valid_ff;
   itc_pkg::rsp_type rsp_ff;

   logic [30:0] q_prod;
   logic [17:0] p0;
   logic over;
   logic [10:0] q_fix;
   logic [17:0] r_fix;
   logic [17:0] q1_prod;
   logic [14:0] q2_prod;
   logic [3:0] q2;
   logic [6:0] d1;
   logic [63:0] load_addr_ext;
   logic [63:0] eff_addr;
   logic [63:0] cur_raw;
   logic [1:0] cur_mode;
   itc_pkg::op_info_type info;
   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;
   logic [63:0] alu_result;

   assign q_prod  = 31'(rdata_ff[16:0]) * 31'(10486);
   assign p0      = 18'(q0_ff) * 18'(100);
   assign over    = p0 > 18'(x_ff);
   assign q_fix   = over ? 11'(q0_ff - 11'd1) : q0_ff;
   assign r_fix   = over ? 18'(18'(x_ff) - p0 + 18'd100) : 18'(18'(x_ff) - p0);
   assign q1_prod = 18'(m_ff) * 18'(205);
   assign q2_prod = 15'(q1_ff) * 15'(205);
   assign q2      = q2_prod[14:11];
   assign d1      = 7'(q1_ff - 7'(7'(q2) * 7'd10));

   assign load_addr_ext = 64'(req_item.load_address);
   assign info          = itc_pkg::op_info(op_ff);
   assign cur_raw       = raw_ff[idx_ff];
   assign cur_mode      = mode_ff[idx_ff];
   assign eff_addr      = ((cur_mode == itc_pkg::MODE_REL) ? base_ff : 64'd0) + cur_raw;

   always_comb begin
      mul_a = val_ff[0][31:0];
      mul_b = val_ff[1][31:0];
      unique case (ctrl.mul_sel)
         itc_pkg::MUL_HL: begin
            mul_a = val_ff[0][63:32];
         end
         itc_pkg::MUL_LH: begin
            mul_b = val_ff[1][63:32];
         end
         default: begin
         end
      endcase
   end

   assign mul_p = 64'(mul_a) * 64'(mul_b);

   always_comb begin
      unique case (op_ff)
         itc_pkg::OP_ADD: alu_result = val_ff[0] + val_ff[1];
         itc_pkg::OP_MUL: alu_result = acc_ff;
         itc_pkg::OP_IN:  alu_result = req_ff.input_value;
         itc_pkg::OP_LT:  alu_result = 64'($signed(val_ff[0]) < $signed(val_ff[1]));
         itc_pkg::OP_EQ:  alu_result = 64'(val_ff[0] == val_ff[1]);
         default:         alu_result = 64'd0;
      endcase
   end

   always_comb begin
      mem_we    = 1'b0;
      mem_wdata = 64'd0;
      mem_addr  = pc_ff[itc_pkg::ADDR_W-1:0];
      unique case (ctrl.mem_sel)
         itc_pkg::MEM_RD_PC: begin
            mem_addr = pc_ff[itc_pkg::ADDR_W-1:0];
         end
         itc_pkg::MEM_RD_RAW: begin
            mem_addr = itc_pkg::ADDR_W'(pc_ff + itc_pkg::PC_W'(idx_ff) + itc_pkg::PC_W'(1));
         end
         itc_pkg::MEM_RD_OPND: begin
            mem_addr = eff_addr[itc_pkg::ADDR_W-1:0];
         end
         itc_pkg::MEM_WR_LOAD: begin
            mem_addr  = load_addr_ext[itc_pkg::ADDR_W-1:0];
            mem_wdata = req_item.load_data;
            mem_we    = 1'b1;
         end
         itc_pkg::MEM_WR_RESULT: begin
            mem_addr  = dst_ff;
            mem_wdata = alu_result;
            mem_we    = 1'b1;
         end
         itc_pkg::MEM_WR_CLEAR: begin
            mem_addr = clr_ff;
            mem_we   = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         word_mem[mem_addr] <= mem_wdata;
      end
      rdata_ff <= word_mem[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= '0;
         base_ff      <= '0;
         halted_ff    <= 1'b0;
         clr_ff       <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ctrl.clr_inc) begin
            clr_ff <= itc_pkg::ADDR_W'(clr_ff + 1'b1);
         end
         if (ctrl.idx_clr) begin
            idx_ff <= '0;
         end else if (ctrl.idx_inc) begin
            idx_ff <= 2'(idx_ff + 2'd1);
         end
         if (ctrl.restart) begin
            pc_ff     <= '0;
            base_ff   <= '0;
            halted_ff <= 1'b0;
         end else begin
            if (ctrl.set_halt) begin
               halted_ff <= 1'b1;
            end
            if (ctrl.pc_jump) begin
               pc_ff <= val_ff[1][itc_pkg::PC_W-1:0];
            end else if (ctrl.pc_advance) begin
               pc_ff <= itc_pkg::PC_W'(pc_ff + itc_pkg::PC_W'(info.nsrc)
                        + itc_pkg::PC_W'(info.ndst) + itc_pkg::PC_W'(1));
            end
            if (ctrl.base_add) begin
               base_ff <= base_ff + val_ff[0];
            end
         end
         rsp_valid_ff <= ctrl.rsp_fire;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.lat_req) begin
         req_ff <= req_item;
      end
      if (ctrl.lat_dec) begin
         x_ff   <= rdata_ff[16:0];
         q0_ff  <= q_prod[30:20];
         neg_ff <= rdata_ff[63];
         big_ff <= rdata_ff[62:0] >= 63'd100000;
      end
      if (ctrl.lat_div) begin
         m_ff  <= q_fix[9:0];
         op_ff <= r_fix[6:0];
      end
      if (ctrl.lat_modes) begin
         q1_ff <= q1_prod[17:11];
         d0_ff <= 4'(m_ff - 10'(10'(q1_prod[17:11]) * 10'd10));
      end
      if (ctrl.lat_digits) begin
         mode_ff[0]  <= d0_ff[1:0];
         mode_ff[1]  <= d1[1:0];
         mode_ff[2]  <= q2[1:0];
         mode_bad_ff <= (d0_ff > 4'd2) || (d1 > 7'd2) || (q2 > 4'd2);
      end
      if (ctrl.lat_raw) begin
         raw_ff[idx_ff] <= rdata_ff;
      end
      if (ctrl.lat_val_imm) begin
         val_ff[idx_ff[0]] <= cur_raw;
      end else if (ctrl.lat_val_mem) begin
         val_ff[idx_ff[0]] <= rdata_ff;
      end
      if (ctrl.lat_dst) begin
         dst_ff <= eff_addr[itc_pkg::ADDR_W-1:0];
      end
      if (ctrl.mul_sel == itc_pkg::MUL_LL) begin
         acc_ff <= mul_p;
      end else if (ctrl.mul_sel != itc_pkg::MUL_NONE) begin
         acc_ff <= acc_ff + {mul_p[31:0], 32'd0};
      end
      if (ctrl.rsp_fire) begin
         rsp_ff.status       <= ctrl.rsp_status;
         rsp_ff.output_value <= ctrl.rsp_out ? val_ff[0] : 64'd0;
         rsp_ff.input_taken  <= ctrl.rsp_taken;
      end
   end

   always_comb begin
      st.clear_done   = clr_ff == itc_pkg::ADDR_W'(itc_pkg::MEMORY_WORDS - 1);
      st.in_cmd       = req_item.cmd;
      st.in_load_bad  = load_addr_ext >= 64'(itc_pkg::MEMORY_WORDS);
      st.halted       = halted_ff;
      st.pc_bad       = pc_ff >= itc_pkg::PC_W'(itc_pkg::MEMORY_WORDS);
      st.word_neg     = neg_ff;
      st.word_big     = big_ff;
      st.mode_bad     = mode_bad_ff;
      st.op           = op_ff;
      st.op_valid     = info.valid;
      st.nsrc         = info.nsrc;
      st.ndst         = info.ndst;
      st.ntot         = 2'(info.nsrc + 2'(info.ndst));
      st.input_valid  = req_ff.input_valid;
      st.pc_over      = ((itc_pkg::PC_W+1)'(pc_ff) + (itc_pkg::PC_W+1)'(info.nsrc)
                        + (itc_pkg::PC_W+1)'(info.ndst))
                        >= (itc_pkg::PC_W+1)'(itc_pkg::MEMORY_WORDS);
      st.idx          = idx_ff;
      st.cur_imm      = cur_mode == itc_pkg::MODE_IMM;
      st.cur_addr_bad = eff_addr >= 64'(itc_pkg::MEMORY_WORDS);
      st.jump_take    = (op_ff == itc_pkg::OP_JT) ? (val_ff[0] != 64'd0)
                                                  : (val_ff[0] == 64'd0);
      st.target_bad   = val_ff[1] >= 64'(itc_pkg::MEMORY_WORDS);
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

[hdl/itc_controller.sv]
// Controller state machine that sequences the phases of each transaction.
`timescale 1ns / 1ps

module itc_controller (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  itc_pkg::stat_type  st,
   output logic               busy,
   output itc_pkg::ctrl_type  ctrl
);

   itc_pkg::state_type state_ff, state_in;
   logic idx_last_tot, idx_last_src;

   assign idx_last_tot = 2'(st.idx + 2'd1) == st.ntot;
   assign idx_last_src = 2'(st.idx + 2'd1) == st.nsrc;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= itc_pkg::S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         itc_pkg::S_CLEAR: begin
            if (st.clear_done) state_in = itc_pkg::S_IDLE;
         end
         itc_pkg::S_IDLE: begin
            if (start && st.in_cmd == itc_pkg::CMD_STEP && !st.halted && !st.pc_bad) begin
               state_in = itc_pkg::S_DEC;
            end
         end
         itc_pkg::S_DEC:    state_in = itc_pkg::S_DIV;
         itc_pkg::S_DIV:    state_in = itc_pkg::S_MODES;
         itc_pkg::S_MODES:  state_in = itc_pkg::S_DIGITS;
         itc_pkg::S_DIGITS: state_in = itc_pkg::S_CHECK;
         itc_pkg::S_CHECK: begin
            priority if (st.word_neg || st.word_big || st.mode_bad) begin
               state_in = itc_pkg::S_IDLE;
            end else if (st.op == itc_pkg::OP_HALT || !st.op_valid) begin
               state_in = itc_pkg::S_IDLE;
            end else if (st.op == itc_pkg::OP_IN && !st.input_valid) begin
               state_in = itc_pkg::S_IDLE;
            end else if (st.pc_over) begin
               state_in = itc_pkg::S_IDLE;
            end else begin
               state_in = itc_pkg::S_RAW_RD;
            end
         end
         itc_pkg::S_RAW_RD: state_in = itc_pkg::S_RAW_LAT;
         itc_pkg::S_RAW_LAT: begin
            if (!idx_last_tot) begin
               state_in = itc_pkg::S_RAW_RD;
            end else if (st.nsrc != 2'd0) begin
               state_in = itc_pkg::S_SRC;
            end else begin
               state_in = itc_pkg::S_DST;
            end
         end
         itc_pkg::S_SRC: begin
            priority if (st.cur_imm) begin
               state_in = idx_last_src ? itc_pkg::S_DST : itc_pkg::S_SRC;
            end else if (st.cur_addr_bad) begin
               state_in = itc_pkg::S_IDLE;
            end else begin
               state_in = itc_pkg::S_SRC_LAT;
            end
         end
         itc_pkg::S_SRC_LAT: begin
            state_in = idx_last_src ? itc_pkg::S_DST : itc_pkg::S_SRC;
         end
         itc_pkg::S_DST: begin
            priority if (!st.ndst) begin
               state_in = itc_pkg::S_EXEC;
            end else if (st.cur_imm || st.cur_addr_bad) begin
               state_in = itc_pkg::S_IDLE;
            end else begin
               state_in = itc_pkg::S_EXEC;
            end
         end
         itc_pkg::S_EXEC: begin
            state_in = (st.op == itc_pkg::OP_MUL) ? itc_pkg::S_MUL_HL : itc_pkg::S_IDLE;
         end
         itc_pkg::S_MUL_HL: state_in = itc_pkg::S_MUL_LH;
         itc_pkg::S_MUL_LH: state_in = itc_pkg::S_MUL_WR;
         itc_pkg::S_MUL_WR: state_in = itc_pkg::S_IDLE;
         default:           state_in = itc_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      ctrl            = '0;
      ctrl.mem_sel    = itc_pkg::MEM_IDLE;
      ctrl.mul_sel    = itc_pkg::MUL_NONE;
      ctrl.rsp_status = itc_pkg::ST_EXECUTED;
      unique case (state_ff)
         itc_pkg::S_CLEAR: begin
            ctrl.mem_sel = itc_pkg::MEM_WR_CLEAR;
            ctrl.clr_inc = 1'b1;
         end
         itc_pkg::S_IDLE: begin
            if (start) begin
               ctrl.lat_req  = 1'b1;
               ctrl.rsp_fire = 1'b1;
               unique case (st.in_cmd)
                  itc_pkg::CMD_LOAD: begin
                     if (st.in_load_bad) begin
                        ctrl.rsp_status = itc_pkg::ST_BAD_ADDRESS;
                     end else begin
                        ctrl.mem_sel    = itc_pkg::MEM_WR_LOAD;
                        ctrl.rsp_status = itc_pkg::ST_DONE;
                     end
                  end
                  itc_pkg::CMD_RESTART: begin
                     ctrl.restart    = 1'b1;
                     ctrl.rsp_status = itc_pkg::ST_DONE;
                  end
                  itc_pkg::CMD_STEP: begin
                     priority if (st.halted) begin
                        ctrl.rsp_status = itc_pkg::ST_HALTED;
                     end else if (st.pc_bad) begin
                        ctrl.rsp_status = itc_pkg::ST_BAD_ADDRESS;
                     end else begin
                        ctrl.rsp_fire = 1'b0;
                        ctrl.mem_sel  = itc_pkg::MEM_RD_PC;
                     end
                  end
                  default: begin
                     ctrl.rsp_status = itc_pkg::ST_BAD_OPCODE;
                  end
               endcase
            end
         end
         itc_pkg::S_DEC:    ctrl.lat_dec = 1'b1;
         itc_pkg::S_DIV:    ctrl.lat_div = 1'b1;
         itc_pkg::S_MODES:  ctrl.lat_modes = 1'b1;
         itc_pkg::S_DIGITS: ctrl.lat_digits = 1'b1;
         itc_pkg::S_CHECK: begin
            ctrl.idx_clr = 1'b1;
            priority if (st.word_neg) begin
               ctrl.rsp_fire   = 1'b1;
               ctrl.rsp_status = itc_pkg::ST_BAD_OPCODE;
            end else if (st.word_big || st.mode_bad) begin
               ctrl.rsp_fire   = 1'b1;
               ctrl.rsp_status = itc_pkg::ST_BAD_MODE;
            end else if (st.op == itc_pkg::OP_HALT) begin
               ctrl.set_halt   = 1'b1;
               ctrl.rsp_fire   = 1'b1;
               ctrl.rsp_status = itc_pkg::ST_HALTED;
            end else if (!st.op_valid) begin
               ctrl.rsp_fire   = 1'b1;
               ctrl.rsp_status = itc_pkg::ST_BAD_OPCODE;
            end else if (st.op == itc_pkg::OP_IN && !st.input_valid) begin
               ctrl.rsp_fire   = 1'b1;
               ctrl.rsp_status = itc_pkg::ST_WAITING;
            end else if (st.pc_over) begin
               ctrl.rsp_fire   = 1'b1;
               ctrl.rsp_status = itc_pkg::ST_BAD_ADDRESS;
            end else begin
            end
         end
         itc_pkg::S_RAW_RD: ctrl.mem_sel = itc_pkg::MEM_RD_RAW;
         itc_pkg::S_RAW_LAT: begin
            ctrl.lat_raw = 1'b1;
            if (idx_last_tot) begin
               ctrl.idx_clr = 1'b1;
            end else begin
               ctrl.idx_inc = 1'b1;
            end
         end
         itc_pkg::S_SRC: begin
            priority if (st.cur_imm) begin
               ctrl.lat_val_imm = 1'b1;
               ctrl.idx_inc     = 1'b1;
            end else if (st.cur_addr_bad) begin
               ctrl.rsp_fire   = 1'b1;
               ctrl.rsp_status = itc_pkg::ST_BAD_ADDRESS;
            end else begin
               ctrl.mem_sel = itc_pkg::MEM_RD_OPND;
            end
         end
         itc_pkg::S_SRC_LAT: begin
            ctrl.lat_val_mem = 1'b1;
            ctrl.idx_inc     = 1'b1;
         end
         itc_pkg::S_DST: begin
            if (st.ndst) begin
               priority if (st.cur_imm) begin
                  ctrl.rsp_fire   = 1'b1;
                  ctrl.rsp_status = itc_pkg::ST_IMM_DEST;
               end else if (st.cur_addr_bad) begin
                  ctrl.rsp_fire   = 1'b1;
                  ctrl.rsp_status = itc_pkg::ST_BAD_ADDRESS;
               end else begin
                  ctrl.lat_dst = 1'b1;
               end
            end
         end
         itc_pkg::S_EXEC: begin
            priority if (st.op == itc_pkg::OP_MUL) begin
               ctrl.mul_sel = itc_pkg::MUL_LL;
            end else if (st.op == itc_pkg::OP_OUT) begin
               ctrl.pc_advance = 1'b1;
               ctrl.rsp_fire   = 1'b1;
               ctrl.rsp_out    = 1'b1;
               ctrl.rsp_status = itc_pkg::ST_OUTPUT;
            end else if (st.op == itc_pkg::OP_ADJ) begin
               ctrl.base_add   = 1'b1;
               ctrl.pc_advance = 1'b1;
               ctrl.rsp_fire   = 1'b1;
            end else if (st.op == itc_pkg::OP_JT || st.op == itc_pkg::OP_JF) begin
               ctrl.rsp_fire = 1'b1;
               if (!st.jump_take) begin
                  ctrl.pc_advance = 1'b1;
               end else if (st.target_bad) begin
                  ctrl.rsp_status = itc_pkg::ST_BAD_ADDRESS;
               end else begin
                  ctrl.pc_jump = 1'b1;
               end
            end else begin
               ctrl.mem_sel    = itc_pkg::MEM_WR_RESULT;
               ctrl.pc_advance = 1'b1;
               ctrl.rsp_fire   = 1'b1;
               ctrl.rsp_taken  = st.op == itc_pkg::OP_IN;
            end
         end
         itc_pkg::S_MUL_HL: ctrl.mul_sel = itc_pkg::MUL_HL;
         itc_pkg::S_MUL_LH: ctrl.mul_sel = itc_pkg::MUL_LH;
         itc_pkg::S_MUL_WR: begin
            ctrl.mem_sel    = itc_pkg::MEM_WR_RESULT;
            ctrl.pc_advance = 1'b1;
            ctrl.rsp_fire   = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign busy = state_ff != itc_pkg::S_IDLE;

endmodule

[hdl/itc_checker.sv]
// Port-level checker for the stepper and its bind to the top level.
`timescale 1ns / 1ps

module itc_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input itc_pkg::req_type req_item,
   input logic             rsp_valid,
   input itc_pkg::rsp_type rsp_item
);

   a_quick_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_item.cmd != itc_pkg::CMD_STEP) |=> rsp_valid)
      else $error("Non-execute transaction did not answer in the next cycle.");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_item.status <= 4'd8))
      else $error("Result status out of range.");

   a_out_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.status != itc_pkg::ST_OUTPUT) |->
         (rsp_item.output_value == 64'd0))
      else $error("Output value nonzero without an output status.");

   a_taken_exec: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.input_taken) |-> (rsp_item.status == itc_pkg::ST_EXECUTED))
      else $error("Input taken on a transaction that did not execute.");

endmodule

bind intcode_instruction_stepper itc_checker u_checker (.*);
